// ----- hw/rtl/ecs_pkg.sv -----
// Package for the embedding cosine similarity core.
// Holds the fixed widths, the status codes and the sequencer state type.
// No dependencies.
package ecs_pkg;

  localparam int ACC_BITS = 48;
  localparam int LIMB_BITS = ACC_BITS / 2;
  localparam int MUL_BITS = LIMB_BITS + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int WIDE_BITS = 131;
  localparam int COUNT_BITS = 16;
  localparam int MAG_BITS = 16;
  localparam int BIT_IDX_BITS = 4;
  localparam int SCORE_BITS = 16;
  localparam int STATUS_BITS = 2;
  localparam int SHIFT_BITS = 7;
  localparam int DOT_SQ_SHIFT = 32;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = 16'h7FFF;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_NORM = 2'd1,
    STATUS_BAD_COUNT = 2'd2
  } status_t;

  typedef enum logic [17:0] {
    IDLE      = 18'h00001,
    MUL_DOT   = 18'h00002,
    ACC_DOT   = 18'h00004,
    ACC_LEFT  = 18'h00008,
    ACC_RIGHT = 18'h00010,
    CHECK     = 18'h00020,
    ABS_DOT   = 18'h00040,
    MUL_P     = 18'h00080,
    ADD_P     = 18'h00100,
    MUL_Q     = 18'h00200,
    ADD_Q     = 18'h00400,
    TRY_SQ    = 18'h00800,
    TRY_SQ_P  = 18'h01000,
    TRY_LIN   = 18'h02000,
    TRY_DIFF  = 18'h04000,
    TRY_ODD   = 18'h08000,
    TRY_CMP   = 18'h10000,
    EMIT      = 18'h20000
  } state_t;

endpackage

// ----- hw/rtl/embedding_cosine_similarity_core.sv -----
// Top level of the embedding cosine similarity core.
// One multiplier and one wide adder shared under a one-hot sequencer.
// Depends on ecs_pkg.
//
// Each input beat carries one element pair and is taken only while the core is idle; it then
// passes through the shared multiplier and adder for the dot product, left square and right
// square before the next beat is taken. On the beat marked last the core adds a check state;
// with a count mismatch or a zero norm it goes straight to the result state. Otherwise it
// forms the absolute dot product, then the product of the two energies and the squared dot
// product from 24-bit limbs, and searches the 16-bit score magnitude one bit at a time with
// a trial square, trial term and compare on the shared adder for each bit. A result waits
// in the output register while new beats are taken; the core stalls before its next result
// until that one is taken.
module embedding_cosine_similarity_core
  import ecs_pkg::*;
#(
  parameter int DIMENSION = 192,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ELEMENT_BITS-1:0] left_element,
  input  logic signed [ELEMENT_BITS-1:0] right_element,
  input  logic                           last_element,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SCORE_BITS-1:0]   score,
  output logic [STATUS_BITS-1:0]         status
);

  state_t state, state_next;

  logic signed [ELEMENT_BITS-1:0] left_reg, right_reg;
  logic last_reg;
  logic [ACC_BITS-1:0] dot_sum, left_energy, right_energy, abs_dot;
  logic dot_neg;
  logic [COUNT_BITS-1:0] element_count;
  logic [1:0] part_idx;
  logic [BIT_IDX_BITS-1:0] bit_idx;
  logic [MAG_BITS-1:0] mag;
  status_t res_status;

  logic [WIDE_BITS-1:0] norm_prod, dot_sq, sq_acc, lin_acc, trial_sq, trial_lin, trial_val;

  logic signed [MUL_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_BITS-1:0] mul_out;
  logic [WIDE_BITS-1:0] prod_wide;
  logic [SHIFT_BITS-1:0] part_shift, shift_b, shift_b1, shift_2b;
  logic [WIDE_BITS-1:0] add_a, add_b, add_sum;
  logic add_sub;
  logic trial_fits, out_load, bad_count, zero_norm;
  logic signed [SCORE_BITS-1:0] score_next;

  assign in_ready = (state == IDLE);
  assign out_load = (state == EMIT) && (!out_valid || out_ready);
  assign bad_count = (element_count != COUNT_BITS'(DIMENSION));
  assign zero_norm = (left_energy == '0) || (right_energy == '0);

  assign prod_wide = {{(WIDE_BITS-ACC_BITS){1'b0}}, mul_out[ACC_BITS-1:0]};
  assign shift_b = {{(SHIFT_BITS-BIT_IDX_BITS){1'b0}}, bit_idx};
  assign shift_b1 = shift_b + 7'd1;
  assign shift_2b = {shift_b[SHIFT_BITS-2:0], 1'b0};

  always_comb begin
    case ({1'b0, part_idx[1]} + {1'b0, part_idx[0]})
      2'd0:    part_shift = 7'd0;
      2'd1:    part_shift = SHIFT_BITS'(LIMB_BITS);
      default: part_shift = SHIFT_BITS'(2 * LIMB_BITS);
    endcase
  end

  always_comb begin
    mul_a = {{(MUL_BITS-ELEMENT_BITS){left_reg[ELEMENT_BITS-1]}}, left_reg};
    mul_b = {{(MUL_BITS-ELEMENT_BITS){right_reg[ELEMENT_BITS-1]}}, right_reg};
    unique case (state)
      ACC_DOT: begin
        mul_b = {{(MUL_BITS-ELEMENT_BITS){left_reg[ELEMENT_BITS-1]}}, left_reg};
      end
      ACC_LEFT: begin
        mul_a = {{(MUL_BITS-ELEMENT_BITS){right_reg[ELEMENT_BITS-1]}}, right_reg};
      end
      MUL_P: begin
        mul_a = {1'b0, part_idx[1] ? left_energy[ACC_BITS-1:LIMB_BITS]
                                   : left_energy[LIMB_BITS-1:0]};
        mul_b = {1'b0, part_idx[0] ? right_energy[ACC_BITS-1:LIMB_BITS]
                                   : right_energy[LIMB_BITS-1:0]};
      end
      MUL_Q: begin
        mul_a = {1'b0, part_idx[1] ? abs_dot[ACC_BITS-1:LIMB_BITS] : abs_dot[LIMB_BITS-1:0]};
        mul_b = {1'b0, part_idx[0] ? abs_dot[ACC_BITS-1:LIMB_BITS] : abs_dot[LIMB_BITS-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_out <= mul_a * mul_b;
  end

  always_comb begin
    add_a = '0;
    add_b = '0;
    add_sub = 1'b0;
    unique case (state)
      ACC_DOT: begin
        add_a = {{(WIDE_BITS-ACC_BITS){1'b0}}, dot_sum};
        add_b = prod_wide;
      end
      ACC_LEFT: begin
        add_a = {{(WIDE_BITS-ACC_BITS){1'b0}}, left_energy};
        add_b = prod_wide;
      end
      ACC_RIGHT: begin
        add_a = {{(WIDE_BITS-ACC_BITS){1'b0}}, right_energy};
        add_b = prod_wide;
      end
      ABS_DOT: begin
        add_b = {{(WIDE_BITS-ACC_BITS){dot_sum[ACC_BITS-1]}}, dot_sum};
        add_sub = dot_sum[ACC_BITS-1];
      end
      ADD_P: begin
        add_a = norm_prod;
        add_b = prod_wide << part_shift;
      end
      ADD_Q: begin
        add_a = dot_sq;
        add_b = prod_wide << (part_shift + SHIFT_BITS'(DOT_SQ_SHIFT));
      end
      TRY_SQ: begin
        add_a = sq_acc;
        add_b = lin_acc << shift_b1;
      end
      TRY_SQ_P: begin
        add_a = trial_sq;
        add_b = norm_prod << shift_2b;
      end
      TRY_LIN: begin
        add_a = lin_acc;
        add_b = norm_prod << shift_b;
      end
      TRY_DIFF: begin
        add_a = trial_sq << 2;
        add_b = trial_lin << 2;
        add_sub = 1'b1;
      end
      TRY_ODD: begin
        add_a = trial_val;
        add_b = norm_prod;
      end
      TRY_CMP: begin
        add_a = dot_sq;
        add_b = trial_val;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(WIDE_BITS-1){1'b0}}, add_sub};
  end

  assign trial_fits = !add_sum[WIDE_BITS-1] && !mag[MAG_BITS-1];

  always_comb begin
    if (res_status != STATUS_OK) begin
      score_next = '0;
    end else if (dot_neg) begin
      score_next = $signed(SCORE_BITS'(0) - mag);
    end else begin
      score_next = $signed(mag[MAG_BITS-1] ? SCORE_MAX : mag);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:      if (in_valid) state_next = MUL_DOT;
      MUL_DOT:   state_next = ACC_DOT;
      ACC_DOT:   state_next = ACC_LEFT;
      ACC_LEFT:  state_next = ACC_RIGHT;
      ACC_RIGHT: state_next = last_reg ? CHECK : IDLE;
      CHECK:     state_next = (bad_count || zero_norm) ? EMIT : ABS_DOT;
      ABS_DOT:   state_next = MUL_P;
      MUL_P:     state_next = ADD_P;
      ADD_P:     state_next = (part_idx == 2'd3) ? MUL_Q : MUL_P;
      MUL_Q:     state_next = ADD_Q;
      ADD_Q:     state_next = (part_idx == 2'd3) ? TRY_SQ : MUL_Q;
      TRY_SQ:    state_next = TRY_SQ_P;
      TRY_SQ_P:  state_next = TRY_LIN;
      TRY_LIN:   state_next = TRY_DIFF;
      TRY_DIFF:  state_next = TRY_ODD;
      TRY_ODD:   state_next = TRY_CMP;
      TRY_CMP:   state_next = (bit_idx == '0) ? EMIT : TRY_SQ;
      EMIT:      if (out_load) state_next = IDLE;
      default:   state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      dot_sum <= '0;
      left_energy <= '0;
      right_energy <= '0;
      element_count <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            left_reg <= left_element;
            right_reg <= right_element;
            last_reg <= last_element;
            if (element_count != '1) begin
              element_count <= element_count + 16'd1;
            end
          end
        end
        ACC_DOT:   dot_sum <= add_sum[ACC_BITS-1:0];
        ACC_LEFT:  left_energy <= add_sum[ACC_BITS-1:0];
        ACC_RIGHT: right_energy <= add_sum[ACC_BITS-1:0];
        CHECK: begin
          if (bad_count) begin
            res_status <= STATUS_BAD_COUNT;
          end else if (zero_norm) begin
            res_status <= STATUS_ZERO_NORM;
          end else begin
            res_status <= STATUS_OK;
          end
        end
        ABS_DOT: begin
          abs_dot <= add_sum[ACC_BITS-1:0];
          dot_neg <= dot_sum[ACC_BITS-1];
          norm_prod <= '0;
          dot_sq <= '0;
          sq_acc <= '0;
          lin_acc <= '0;
          mag <= '0;
          bit_idx <= '1;
          part_idx <= '0;
        end
        ADD_P: begin
          norm_prod <= add_sum;
          part_idx <= part_idx + 2'd1;
        end
        ADD_Q: begin
          dot_sq <= add_sum;
          part_idx <= part_idx + 2'd1;
        end
        TRY_SQ:   trial_sq <= add_sum;
        TRY_SQ_P: trial_sq <= add_sum;
        TRY_LIN:  trial_lin <= add_sum;
        TRY_DIFF: trial_val <= add_sum;
        TRY_ODD:  trial_val <= add_sum;
        TRY_CMP: begin
          if (trial_fits) begin
            sq_acc <= trial_sq;
            lin_acc <= trial_lin;
            mag[bit_idx] <= 1'b1;
          end
          bit_idx <= bit_idx - 4'd1;
        end
        EMIT: begin
          if (out_load) begin
            score <= score_next;
            status <= res_status;
            dot_sum <= '0;
            left_energy <= '0;
            right_energy <= '0;
            element_count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- dv/embedding_cosine_similarity_checker.sv -----
// Checker for the embedding cosine similarity core: watches both channels,
// predicts each score and status from the element pairs, and compares.
// Depends on ecs_pkg.
`timescale 1ns / 100ps

module embedding_cosine_similarity_checker
  import ecs_pkg::*;
#(
  parameter int DIMENSION = 192,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [ELEMENT_BITS-1:0] left_element,
  input  logic signed [ELEMENT_BITS-1:0] right_element,
  input  logic                           last_element,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [SCORE_BITS-1:0]   score,
  input  logic [STATUS_BITS-1:0]         status,
  output int unsigned                    mismatch_count,
  output int unsigned                    outstanding_results
);

  localparam int PRODUCT_BITS = 160;
  localparam int MAG_LIMIT = 32768;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    status_t                      status;
  } cosine_result_t;

  cosine_result_t          expected_cosines[$];
  logic [ACC_BITS-1:0]     dot_acc;
  logic [ACC_BITS-1:0]     left_acc;
  logic [ACC_BITS-1:0]     right_acc;
  logic [COUNT_BITS-1:0]   pair_count;
  int unsigned             results_seen;

  initial begin
    mismatch_count = 0;
    outstanding_results = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: result beat %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  // The magnitude is the largest k with (2k-1)^2 * L * R <= 2^32 * dot^2,
  // which rounds half away from zero without any division.
  function automatic logic signed [SCORE_BITS-1:0] cosine_score(
      input logic [ACC_BITS-1:0] dot,
      input logic [ACC_BITS-1:0] lft,
      input logic [ACC_BITS-1:0] rgt);
    logic [ACC_BITS-1:0]     dot_mag;
    logic [PRODUCT_BITS-1:0] energy_prod;
    logic [PRODUCT_BITS-1:0] dot_sq;
    logic [PRODUCT_BITS-1:0] odd;
    int unsigned             lo;
    int unsigned             hi;
    int unsigned             mid;
    dot_mag = dot[ACC_BITS-1] ? -dot : dot;
    energy_prod = PRODUCT_BITS'(lft) * PRODUCT_BITS'(rgt);
    dot_sq = (PRODUCT_BITS'(dot_mag) * PRODUCT_BITS'(dot_mag)) << DOT_SQ_SHIFT;
    lo = 0;
    hi = MAG_LIMIT;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = PRODUCT_BITS'(2 * mid - 1);
      if (energy_prod * odd * odd <= dot_sq) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (dot[ACC_BITS-1]) begin
      return SCORE_BITS'(0 - lo);
    end
    return (lo >= MAG_LIMIT) ? SCORE_MAX : SCORE_BITS'(lo);
  endfunction

  always @(posedge clk) begin
    cosine_result_t             want;
    logic signed [ACC_BITS-1:0] left_ext;
    logic signed [ACC_BITS-1:0] right_ext;
    if (rst) begin
      dot_acc = '0;
      left_acc = '0;
      right_acc = '0;
      pair_count = '0;
      expected_cosines.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_cosines.size() == 0) begin
          report_mismatch($sformatf("score %0d status %0d arrived with none expected",
                                    score, status));
        end else begin
          want = expected_cosines.pop_front();
          if (score !== want.score) begin
            report_mismatch($sformatf("score %0d, expected %0d", score, want.score));
          end
          if (status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          end
        end
      end
      if (in_valid && in_ready) begin
        left_ext = left_element;
        right_ext = right_element;
        dot_acc = dot_acc + left_ext * right_ext;
        left_acc = left_acc + left_ext * left_ext;
        right_acc = right_acc + right_ext * right_ext;
        if (pair_count != '1) begin
          pair_count = pair_count + 1'b1;
        end
        if (last_element) begin
          want.score = '0;
          if (pair_count != DIMENSION) begin
            want.status = STATUS_BAD_COUNT;
          end else if (left_acc == '0 || right_acc == '0) begin
            want.status = STATUS_ZERO_NORM;
          end else begin
            want.status = STATUS_OK;
            want.score = cosine_score(dot_acc, left_acc, right_acc);
          end
          expected_cosines.push_back(want);
          dot_acc = '0;
          left_acc = '0;
          right_acc = '0;
          pair_count = '0;
        end
      end
    end
    outstanding_results = expected_cosines.size();
  end

endmodule

// ----- dv/embedding_cosine_similarity_core_tb.sv -----
// Top of the testbench for the embedding cosine similarity core: clock, reset,
// element pair stimulus, result back-pressure and the verdict.
// Depends on ecs_pkg, embedding_cosine_similarity_core and its checker.
`timescale 1ns / 100ps

module embedding_cosine_similarity_core_tb;
  import ecs_pkg::*;

  localparam int DIMENSION = 192;
  localparam int ELEMENT_BITS = 16;
  localparam int HOLD_CYCLES = 2000;
  localparam int RANDOM_PAIRS = 60;
  localparam int RANDOM_VECTORS = 8;
  localparam int SETTLE_CYCLES = 200;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_SAME,
    SHAPE_OPPOSITE,
    SHAPE_NEAR,
    SHAPE_SPLIT,
    SHAPE_ZERO_LEFT,
    SHAPE_ZERO_RIGHT,
    SHAPE_SMALL,
    SHAPE_EXTREME
  } vector_shape_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idling_e;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [ELEMENT_BITS-1:0] left_element = '0;
  logic signed [ELEMENT_BITS-1:0] right_element = '0;
  logic                           last_element = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [SCORE_BITS-1:0]   score;
  logic [STATUS_BITS-1:0]         status;
  int unsigned                    mismatch_count;
  int unsigned                    outstanding_results;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  embedding_cosine_similarity_core #(
    .DIMENSION(DIMENSION),
    .ELEMENT_BITS(ELEMENT_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .left_element(left_element),
    .right_element(right_element),
    .last_element(last_element),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .score(score),
    .status(status)
  );

  embedding_cosine_similarity_checker #(
    .DIMENSION(DIMENSION),
    .ELEMENT_BITS(ELEMENT_BITS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .left_element(left_element),
    .right_element(right_element),
    .last_element(last_element),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .score(score),
    .status(status),
    .mismatch_count(mismatch_count),
    .outstanding_results(outstanding_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("embedding_cosine_similarity_core_tb failed");
    $finish;
  end

  // A long hold-off is counted here so that the sender keeps offering beats.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input idling_e mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 76;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 76;
      end
      IDLE_BOTH: begin
        send_idle_pct = 33;
        recv_stall_pct = 33;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_pair(input logic signed [ELEMENT_BITS-1:0] l,
                           input logic signed [ELEMENT_BITS-1:0] r,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    left_element <= l;
    right_element <= r;
    last_element <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding_results != 0) @(posedge clk);
  endtask

  function automatic logic signed [ELEMENT_BITS-1:0] extreme_element();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh8001;
      2: return 16'shFFFF;
      3: return 16'sh0000;
      4: return 16'sh0001;
      default: return 16'sh7FFF;
    endcase
  endfunction

  function automatic logic signed [ELEMENT_BITS-1:0] small_element();
    return ELEMENT_BITS'($signed($urandom_range(0, 511)) - 256);
  endfunction

  task automatic send_vector(input int length, input vector_shape_e shape);
    logic signed [ELEMENT_BITS-1:0] l;
    logic signed [ELEMENT_BITS-1:0] r;
    int                             near;
    for (int i = 0; i < length; i++) begin
      l = ELEMENT_BITS'($urandom);
      r = ELEMENT_BITS'($urandom);
      case (shape)
        SHAPE_SAME: r = l;
        SHAPE_OPPOSITE: begin
          if (l == 16'sh8000) begin
            l = 16'sh8001;
          end
          r = -l;
        end
        SHAPE_NEAR: begin
          near = int'(l) + $urandom_range(0, 64) - 32;
          if (near > 32767) begin
            near = 32767;
          end else if (near < -32768) begin
            near = -32768;
          end
          r = ELEMENT_BITS'(near);
        end
        SHAPE_SPLIT: begin
          if (i % 2 == 0) begin
            r = '0;
          end else begin
            l = '0;
          end
        end
        SHAPE_ZERO_LEFT: l = '0;
        SHAPE_ZERO_RIGHT: r = '0;
        SHAPE_SMALL: begin
          l = small_element();
          r = small_element();
        end
        SHAPE_EXTREME: begin
          l = extreme_element();
          r = extreme_element();
        end
        default: ;
      endcase
      send_pair(l, r, i == length - 1);
    end
  endtask

  initial begin
    int            random_pairs;
    int            random_vectors;
    int            length;
    vector_shape_e shape;
    set_idling(IDLE_NONE);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);
    send_pair(16'shFFFF, 16'sh0001, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b0);
    send_pair(16'sh0001, 16'shFFFF, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_pair(16'sh8001, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh8001, 1'b0);
    send_pair(16'sh5555, 16'shAAAA, 1'b0);
    send_pair(16'shAAAA, 16'sh5555, 1'b1);
    wait_drained();

    for (int s = 0; s <= int'(SHAPE_EXTREME); s++) begin
      if (vector_shape_e'(s) != SHAPE_SMALL) begin
        set_idling(idling_e'(s % 4));
        send_vector(DIMENSION, vector_shape_e'(s));
      end
    end
    set_idling(IDLE_BOTH);
    send_vector(DIMENSION - 1, SHAPE_RANDOM);
    send_vector(DIMENSION + 1, SHAPE_SAME);
    wait_drained();

    set_idling(IDLE_NONE);
    hold_requests <= hold_requests + 1;
    repeat (4) send_vector(2, SHAPE_RANDOM);
    wait_drained();

    random_pairs = 0;
    random_vectors = 0;
    while (random_pairs < RANDOM_PAIRS || random_vectors < RANDOM_VECTORS) begin
      set_idling(idling_e'(random_vectors % 4));
      shape = vector_shape_e'($urandom_range(int'(SHAPE_EXTREME)));
      length = $urandom_range(1, 24);
      send_vector(length, shape);
      random_pairs += length;
      random_vectors++;
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outstanding_results == 0) begin
      $display("embedding_cosine_similarity_core_tb passed");
    end else begin
      $display("embedding_cosine_similarity_core_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ecs_pkg.sv
hw/rtl/embedding_cosine_similarity_core.sv
dv/embedding_cosine_similarity_checker.sv
dv/embedding_cosine_similarity_core_tb.sv
